// ===== rtl/hc_pkg.sv =====
// Shared types, constants and modulo-26 helpers for the 2x2 Hill cipher block.
`timescale 1ns / 1ps

package hc_pkg;

  localparam int unsigned Modulus    = 26;
  localparam int unsigned LetterBase = 65;
  localparam int unsigned LetterOfs  = 13;
  localparam int unsigned ModSq      = Modulus * Modulus;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned Recip26    = ((1 << RecipShift) + Modulus - 1) / Modulus;

  localparam logic [4:0] KeyR0C0Rst = 5'd3;
  localparam logic [4:0] KeyR0C1Rst = 5'd3;
  localparam logic [4:0] KeyR1C0Rst = 5'd2;
  localparam logic [4:0] KeyR1C1Rst = 5'd5;
  localparam logic       ModeRst    = 1'b0;

  typedef enum logic [2:0] {
    CfgKeyR0C0 = 3'd0,
    CfgKeyR0C1 = 3'd1,
    CfgKeyR1C0 = 3'd2,
    CfgKeyR1C1 = 3'd3,
    CfgMode    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ModeEncrypt = 1'b0,
    ModeDecrypt = 1'b1
  } mode_e;

  typedef struct packed {
    logic [4:0] k00;
    logic [4:0] k01;
    logic [4:0] k10;
    logic [4:0] k11;
    mode_e      mode;
  } key_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] m00;
    logic [4:0] m01;
    logic [4:0] m10;
    logic [4:0] m11;
    logic       err;
  } mat_t;

  // Reduce a value below 4096 modulo 26 by reciprocal multiply and one correction.
  function automatic logic [4:0] mod26_f(input logic [11:0] v);
    logic [24:0] prod;
    logic [11:0] q;
    logic [11:0] r;
    prod = {13'd0, v} * 25'(Recip26);
    q    = 12'(prod >> RecipShift);
    r    = v - 12'(q * 12'(Modulus));
    if (r >= 12'(Modulus)) begin
      r = r - 12'(Modulus);
    end
    return r[4:0];
  endfunction

  // Multiplicative inverse modulo 26; zero means none exists.
  function automatic logic [4:0] inv26_f(input logic [4:0] v);
    logic [4:0] r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hc_matrix.sv =====
// Four-stage pipeline that reduces the letters and builds the encrypt or decrypt matrix.
`timescale 1ns / 1ps

module hc_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [6:0]      first_letter_i,
  input  logic [6:0]      second_letter_i,
  input  hc_pkg::key_t    key_i,
  output hc_pkg::mat_t    mat_o
);

  // stage 1: reduced letters and key, determinant products
  logic        v1_q;
  logic [4:0]  x1_q, y1_q, a1_q, b1_q, c1_q, d1_q;
  logic [9:0]  ad1_q, bc1_q;
  hc_pkg::mode_e mode1_q;
  logic [4:0]  a1_d, b1_d, c1_d, d1_d;

  // stage 2: determinant
  logic        v2_q;
  logic [4:0]  x2_q, y2_q, a2_q, b2_q, c2_q, d2_q, det2_q;
  hc_pkg::mode_e mode2_q;
  logic [11:0] det2_sum;

  // stage 3: raw matrix products
  logic        v3_q;
  logic [4:0]  x3_q, y3_q;
  logic [9:0]  n00_q, n01_q, n10_q, n11_q;
  logic        err3_q;
  logic [4:0]  inv3_d, nb3_d, nc3_d;

  // stage 4: reduced matrix
  logic        v4_q;
  logic [4:0]  x4_q, y4_q, m00_q, m01_q, m10_q, m11_q;
  logic        err4_q;

  always_comb begin
    a1_d = (key_i.k00 >= 5'(hc_pkg::Modulus)) ? key_i.k00 - 5'(hc_pkg::Modulus) : key_i.k00;
    b1_d = (key_i.k01 >= 5'(hc_pkg::Modulus)) ? key_i.k01 - 5'(hc_pkg::Modulus) : key_i.k01;
    c1_d = (key_i.k10 >= 5'(hc_pkg::Modulus)) ? key_i.k10 - 5'(hc_pkg::Modulus) : key_i.k10;
    d1_d = (key_i.k11 >= 5'(hc_pkg::Modulus)) ? key_i.k11 - 5'(hc_pkg::Modulus) : key_i.k11;
  end

  assign det2_sum = 12'({2'd0, ad1_q} + 12'(hc_pkg::ModSq) - {2'd0, bc1_q});

  always_comb begin
    inv3_d = hc_pkg::inv26_f(det2_q);
    nb3_d  = (b2_q == 5'd0) ? 5'd0 : 5'(hc_pkg::Modulus) - b2_q;
    nc3_d  = (c2_q == 5'd0) ? 5'd0 : 5'(hc_pkg::Modulus) - c2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= hc_pkg::mod26_f({5'd0, first_letter_i} + 12'(hc_pkg::LetterOfs));
    y1_q    <= hc_pkg::mod26_f({5'd0, second_letter_i} + 12'(hc_pkg::LetterOfs));
    a1_q    <= a1_d;
    b1_q    <= b1_d;
    c1_q    <= c1_d;
    d1_q    <= d1_d;
    ad1_q   <= {5'd0, a1_d} * {5'd0, d1_d};
    bc1_q   <= {5'd0, b1_d} * {5'd0, c1_d};
    mode1_q <= key_i.mode;

    x2_q    <= x1_q;
    y2_q    <= y1_q;
    a2_q    <= a1_q;
    b2_q    <= b1_q;
    c2_q    <= c1_q;
    d2_q    <= d1_q;
    det2_q  <= hc_pkg::mod26_f(det2_sum);
    mode2_q <= mode1_q;

    x3_q <= x2_q;
    y3_q <= y2_q;
    if (mode2_q == hc_pkg::ModeDecrypt) begin
      n00_q  <= {5'd0, d2_q} * {5'd0, inv3_d};
      n01_q  <= {5'd0, nb3_d} * {5'd0, inv3_d};
      n10_q  <= {5'd0, nc3_d} * {5'd0, inv3_d};
      n11_q  <= {5'd0, a2_q} * {5'd0, inv3_d};
      err3_q <= (inv3_d == 5'd0);
    end else begin
      n00_q  <= {5'd0, a2_q};
      n01_q  <= {5'd0, b2_q};
      n10_q  <= {5'd0, c2_q};
      n11_q  <= {5'd0, d2_q};
      err3_q <= 1'b0;
    end

    x4_q   <= x3_q;
    y4_q   <= y3_q;
    m00_q  <= hc_pkg::mod26_f({2'd0, n00_q});
    m01_q  <= hc_pkg::mod26_f({2'd0, n01_q});
    m10_q  <= hc_pkg::mod26_f({2'd0, n10_q});
    m11_q  <= hc_pkg::mod26_f({2'd0, n11_q});
    err4_q <= err3_q;
  end

  always_comb begin
    mat_o.valid = v4_q;
    mat_o.x     = x4_q;
    mat_o.y     = y4_q;
    mat_o.m00   = m00_q;
    mat_o.m01   = m01_q;
    mat_o.m10   = m10_q;
    mat_o.m11   = m11_q;
    mat_o.err   = err4_q;
  end

endmodule

// ===== rtl/hc_apply.sv =====
// Two-stage pipeline that multiplies the letter vector by the matrix and forms the result.
`timescale 1ns / 1ps

module hc_apply (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hc_pkg::mat_t mat_i,
  output logic         out_valid_o,
  output logic [6:0]   out_first_o,
  output logic [6:0]   out_second_o,
  output logic         key_not_invertible_o
);

  logic       v5_q, v6_q;
  logic [10:0] p0_q, p1_q;
  logic       err5_q, err6_q;
  logic [6:0] first6_q, second6_q;
  logic [4:0] r0_d, r1_d;

  assign r0_d = hc_pkg::mod26_f({1'd0, p0_q});
  assign r1_d = hc_pkg::mod26_f({1'd0, p1_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v5_q <= mat_i.valid;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= 11'({6'd0, mat_i.m00} * {6'd0, mat_i.x}) + 11'({6'd0, mat_i.m01} * {6'd0, mat_i.y});
    p1_q   <= 11'({6'd0, mat_i.m10} * {6'd0, mat_i.x}) + 11'({6'd0, mat_i.m11} * {6'd0, mat_i.y});
    err5_q <= mat_i.err;

    err6_q <= err5_q;
    if (err5_q) begin
      first6_q  <= 7'(hc_pkg::LetterBase);
      second6_q <= 7'(hc_pkg::LetterBase);
    end else begin
      first6_q  <= {2'd0, r0_d} + 7'(hc_pkg::LetterBase);
      second6_q <= {2'd0, r1_d} + 7'(hc_pkg::LetterBase);
    end
  end

  assign out_valid_o          = v6_q;
  assign out_first_o          = first6_q;
  assign out_second_o         = second6_q;
  assign key_not_invertible_o = err6_q;

endmodule

// ===== rtl/hill_cipher_2x2.sv =====
// Top level of the 2x2 modulo-26 Hill cipher: key registers and the cipher pipeline.
//
//   channel   handshake                 payload
//   request   start high, busy low      first_letter_i, second_letter_i
//   result    out_valid_o, one cycle    out_first_o, out_second_o, key_not_invertible_o
//   config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Requests are accepted one per cycle, and results leave in the order taken.
// The cipher pipeline has six register stages: letter reduction, determinant, inverse,
// matrix reduction, vector product, final reduction.
// Reset clears the key to its defaults and empties the pipeline; busy stays low.
// The result receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module hill_cipher_2x2 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] first_letter_i,
  input  logic [6:0] second_letter_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output logic       out_valid_o,
  output logic [6:0] out_first_o,
  output logic [6:0] out_second_o,
  output logic       key_not_invertible_o
);

  hc_pkg::key_t key_q;
  hc_pkg::mat_t mat;
  logic         cfg_we;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.k00  <= hc_pkg::KeyR0C0Rst;
      key_q.k01  <= hc_pkg::KeyR0C1Rst;
      key_q.k10  <= hc_pkg::KeyR1C0Rst;
      key_q.k11  <= hc_pkg::KeyR1C1Rst;
      key_q.mode <= hc_pkg::mode_e'(hc_pkg::ModeRst);
    end else if (cfg_we) begin
      case (hc_pkg::cfg_idx_e'(cfg_index_i))
        hc_pkg::CfgKeyR0C0: key_q.k00  <= cfg_data_i;
        hc_pkg::CfgKeyR0C1: key_q.k01  <= cfg_data_i;
        hc_pkg::CfgKeyR1C0: key_q.k10  <= cfg_data_i;
        hc_pkg::CfgKeyR1C1: key_q.k11  <= cfg_data_i;
        hc_pkg::CfgMode:    key_q.mode <= hc_pkg::mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  hc_matrix u_matrix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (start & ~busy),
    .first_letter_i  (first_letter_i),
    .second_letter_i (second_letter_i),
    .key_i           (key_q),
    .mat_o           (mat)
  );

  hc_apply u_apply (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .mat_i                (mat),
    .out_valid_o          (out_valid_o),
    .out_first_o          (out_first_o),
    .out_second_o         (out_second_o),
    .key_not_invertible_o (key_not_invertible_o)
  );

endmodule

// ===== test/tb_hill_cipher_2x2.sv =====
// Self-checking testbench for the 2x2 modulo-26 Hill cipher block.
`timescale 1ns / 1ps

module tb_hill_cipher_2x2;
  import hc_pkg::*;

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 160;
  localparam int unsigned IdlePct      = 12;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
  } letter_pair_t;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic       bad_key;
  } cipher_out_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       start           = 1'b0;
  logic       busy;
  logic [6:0] first_letter_i  = '0;
  logic [6:0] second_letter_i = '0;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i     = '0;
  logic [4:0] cfg_data_i      = '0;
  logic       out_valid_o;
  logic [6:0] out_first_o;
  logic [6:0] out_second_o;
  logic       key_not_invertible_o;

  letter_pair_t pending_pairs[$];
  cipher_out_t  expected_outs[$];
  logic [4:0]   key_copy[4];
  mode_e        mode_copy;
  logic         req_taken  = 1'b0;
  int unsigned  idle_pct   = 0;
  int unsigned  mismatches = 0;

  hill_cipher_2x2 i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .first_letter_i      (first_letter_i),
    .second_letter_i     (second_letter_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_first_o         (out_first_o),
    .out_second_o        (out_second_o),
    .key_not_invertible_o(key_not_invertible_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic cipher_out_t cipher_pair(input logic [6:0] p, input logic [6:0] q);
    int unsigned a, b, c, d, x, y, det, inv;
    int unsigned m00, m01, m10, m11;
    cipher_out_t r;
    a = key_copy[0] % Modulus;
    b = key_copy[1] % Modulus;
    c = key_copy[2] % Modulus;
    d = key_copy[3] % Modulus;
    x = (int'(p) + Modulus - LetterBase % Modulus) % Modulus;
    y = (int'(q) + Modulus - LetterBase % Modulus) % Modulus;
    m00 = a;
    m01 = b;
    m10 = c;
    m11 = d;
    r.bad_key = 1'b0;
    if (mode_copy == ModeDecrypt) begin
      det = (a * d + Modulus * Modulus - b * c) % Modulus;
      inv = 0;
      for (int unsigned k = 1; k < Modulus; k++) begin
        if (inv == 0 && (det * k) % Modulus == 1) inv = k;
      end
      if (inv == 0) begin
        r.first   = 7'(LetterBase);
        r.second  = 7'(LetterBase);
        r.bad_key = 1'b1;
        return r;
      end
      m00 = (d * inv) % Modulus;
      m01 = (((Modulus - b) % Modulus) * inv) % Modulus;
      m10 = (((Modulus - c) % Modulus) * inv) % Modulus;
      m11 = (a * inv) % Modulus;
    end
    r.first  = 7'((m00 * x + m01 * y) % Modulus + LetterBase);
    r.second = 7'((m10 * x + m11 * y) % Modulus + LetterBase);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Track config, predict accepted requests, check results.
  always @(posedge clk_i) begin
    cipher_out_t exp_o;
    if (!rst_ni) begin
      key_copy[0] = KeyR0C0Rst;
      key_copy[1] = KeyR0C1Rst;
      key_copy[2] = KeyR1C0Rst;
      key_copy[3] = KeyR1C1Rst;
      mode_copy   = mode_e'(ModeRst);
      req_taken   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgKeyR0C0: key_copy[0] = cfg_data_i;
          CfgKeyR0C1: key_copy[1] = cfg_data_i;
          CfgKeyR1C0: key_copy[2] = cfg_data_i;
          CfgKeyR1C1: key_copy[3] = cfg_data_i;
          CfgMode:    mode_copy = mode_e'(cfg_data_i[0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_outs.push_back(cipher_pair(first_letter_i, second_letter_i));
      end
      req_taken <= start && !busy;
      if (out_valid_o) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d %0d %0d", $time,
                   out_first_o, out_second_o, key_not_invertible_o);
          mismatches++;
        end else begin
          exp_o = expected_outs.pop_front();
          check_field("out_first", 32'(exp_o.first), 32'(out_first_o));
          check_field("out_second", 32'(exp_o.second), 32'(out_second_o));
          check_field("key_not_invertible", 32'(exp_o.bad_key),
                      32'(key_not_invertible_o));
        end
      end
    end
  end

  // Hold a request until taken, then send the next one or idle.
  always @(negedge clk_i) begin
    letter_pair_t pr;
    if (rst_ni && !(start && !req_taken)) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        pr = pending_pairs.pop_front();
        start           <= 1'b1;
        first_letter_i  <= pr.first;
        second_letter_i <= pr.second;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [4:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic key_write(input logic [4:0] k0, input logic [4:0] k1,
                           input logic [4:0] k2, input logic [4:0] k3);
    cfg_write(CfgKeyR0C0, k0);
    cfg_write(CfgKeyR0C1, k1);
    cfg_write(CfgKeyR1C0, k2);
    cfg_write(CfgKeyR1C1, k3);
  endtask

  task automatic push_pair(input logic [6:0] f, input logic [6:0] s);
    letter_pair_t pr;
    pr.first  = f;
    pr.second = s;
    pending_pairs.push_back(pr);
  endtask

  task automatic push_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) begin
        push_pair(7'($urandom_range(90, 65)), 7'($urandom_range(90, 65)));
      end else begin
        push_pair(7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || start || expected_outs.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [4:0] rand_key();
    return ($urandom_range(99) < 80) ? 5'($urandom_range(25)) : 5'($urandom_range(31));
  endfunction

  initial begin : stimulus
    logic [4:0] kv[4];
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, encrypt: letter extremes and codes outside the alphabet
    push_pair(7'("A"), 7'("A"));
    push_pair(7'("Z"), 7'("Z"));
    push_pair(7'("A"), 7'("Z"));
    push_pair(7'("Z"), 7'("A"));
    push_pair(7'("H"), 7'("I"));
    push_pair(7'h00, 7'h7f);
    push_pair(7'h7f, 7'h00);
    push_pair(7'("["), 7'("@"));
    wait_drained();

    cfg_write(CfgMode, 5'(ModeDecrypt));
    cfg_release();
    push_pair(7'("Z"), 7'("Z"));
    push_pair(7'("A"), 7'("A"));
    push_pair(7'h7f, 7'h7f);
    wait_drained();

    // determinant without inverse: even, then thirteen
    key_write(5'd2, 5'd4, 5'd6, 5'd8);
    cfg_release();
    push_pair(7'("A"), 7'("A"));
    push_pair(7'("M"), 7'("Z"));
    push_pair(7'h00, 7'h7f);
    wait_drained();
    key_write(5'd1, 5'd0, 5'd0, 5'd13);
    cfg_release();
    push_pair(7'("Q"), 7'("B"));
    push_pair(7'("Z"), 7'("A"));
    wait_drained();

    // key values above 25, then ignored register indexes
    key_write(5'd31, 5'd26, 5'd30, 5'd27);
    cfg_release();
    push_pair(7'("K"), 7'("Y"));
    push_pair(7'("Z"), 7'("Z"));
    wait_drained();
    cfg_write(CfgMode, 5'(ModeEncrypt));
    cfg_write(3'(CfgMode) + 3'd1, 5'h1f);
    cfg_write(3'(CfgMode) + 3'd3, 5'h1f);
    cfg_release();
    push_pair(7'("K"), 7'("Y"));
    push_pair(7'("A"), 7'("Z"));
    wait_drained();
    key_write(5'd0, 5'd0, 5'd0, 5'd0);
    cfg_release();
    push_pair(7'("Z"), 7'("Z"));
    wait_drained();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      idle_pct = (ph == 2) ? 0 : IdlePct;
      for (int i = 0; i < 4; i++) begin
        kv[i] = (ph == 0) ? 5'd31 : (ph == 1) ? 5'd25 : rand_key();
      end
      key_write(kv[0], kv[1], kv[2], kv[3]);
      cfg_write(CfgMode, 5'($urandom_range(31)));
      if ($urandom_range(1) == 1) begin
        cfg_write(3'(CfgMode) + 3'($urandom_range(3, 1)), 5'($urandom_range(31)));
      end
      cfg_release();
      push_random(PhaseItems / 2);
      if (ph % 3 == 0) wait_drained();
      push_random(PhaseItems - PhaseItems / 2);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("hill_cipher_2x2 test passed");
    end else begin
      $display("hill_cipher_2x2 test failed");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("hill_cipher_2x2 test failed");
    $finish;
  end

endmodule
